/* src/csc_pkg.sv */
// Shared types, widths and constants of the CORDIC sine/cosine pipeline.
package csc_pkg;

  // Number of micro-rotations; steps beyond the arctangent table are not run.
  localparam int unsigned ITERATIONS = 16;
  localparam int unsigned ATAN_DEPTH = 32;
  localparam int unsigned STEPS      = (ITERATIONS < ATAN_DEPTH) ? ITERATIONS : ATAN_DEPTH;
  localparam int unsigned STEP_W     = $clog2(ATAN_DEPTH);

  // Field widths at the ports.
  localparam int unsigned ANGLE_W = 18;
  localparam int unsigned OUT_W   = 18;

  // Datapath widths: vector and angle in signed Q.30.
  localparam int unsigned XY_W    = 32;
  localparam int unsigned THETA_W = 32;
  localparam int unsigned TGT_SHIFT = 14;

  // Gain 0.607259 in Q0.30 and output scaling from Q.60 to Q.16.
  localparam int unsigned GAIN_W    = 31;
  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652039386;
  localparam int unsigned PROD_W    = XY_W + GAIN_W;
  localparam int unsigned OUT_SHIFT = 44;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (OUT_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] OUT_MAX    = PROD_W'(64'sd65536);

  // Unit vector start value in Q.30.
  localparam logic signed [XY_W-1:0] X_START = XY_W'(64'sd1 <<< 30);

  // round(atan(2^-i) * 2^30)
  localparam logic signed [THETA_W-1:0] ATAN_Q30 [ATAN_DEPTH] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,
    32'sd64,        32'sd32,        32'sd16,        32'sd8,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  // Payload handed from cell to cell.
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [THETA_W-1:0] theta;
    logic signed [THETA_W-1:0] target;
  } csc_vec_t;

endpackage

/* src/csc_cell.sv */
// One CORDIC micro-rotation cell with its pipeline register.
module csc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [csc_pkg::STEP_W-1:0] step_i,
  input  logic                     vld_i,
  input  csc_pkg::csc_vec_t        vec_i,
  output logic                     vld_o,
  output csc_pkg::csc_vec_t        vec_o
);
  import csc_pkg::*;

  logic signed [XY_W-1:0] dx, dy;
  logic                   rot_up;
  csc_vec_t               vec_d, vec_q;
  logic                   vld_q;

  // Rotate toward the target by atan(2^-step)
  always_comb begin
    dx     = vec_i.y >>> step_i;
    dy     = vec_i.x >>> step_i;
    rot_up = vec_i.theta < vec_i.target;
    vec_d  = vec_i;
    if (rot_up) begin
      vec_d.theta = vec_i.theta + ATAN_Q30[step_i];
      vec_d.x     = vec_i.x - dx;
      vec_d.y     = vec_i.y + dy;
    end else begin
      vec_d.theta = vec_i.theta - ATAN_Q30[step_i];
      vec_d.x     = vec_i.x + dx;
      vec_d.y     = vec_i.y - dy;
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Hold the rotated vector for the next cell
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vld_o = vld_q;
  assign vec_o = vec_q;

endmodule

/* src/csc_gain.sv */
// Gain correction, rounding and saturation of the final vector.
module csc_gain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  csc_pkg::csc_vec_t                 vec_i,
  output logic                              done_o,
  output logic signed [csc_pkg::OUT_W-1:0]  cosine_o,
  output logic signed [csc_pkg::OUT_W-1:0]  sine_o
);
  import csc_pkg::*;

  logic signed [PROD_W-1:0] cos_prod_q, sin_prod_q;
  logic                     prod_vld_q;
  logic signed [OUT_W-1:0]  cos_d, sin_d, cos_q, sin_q;
  logic                     done_q;

  // Round half up from Q.60 to Q.16 and clamp to plus or minus one
  function automatic logic signed [OUT_W-1:0] scale_out(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + ROUND_HALF) >>> OUT_SHIFT;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < -OUT_MAX) begin
      r = -OUT_MAX;
    end
    return r[OUT_W-1:0];
  endfunction

  // Multiply by the gain
  always_ff @(posedge clk_i) begin
    cos_prod_q <= PROD_W'(vec_i.x) * PROD_W'(GAIN_Q30);
    sin_prod_q <= PROD_W'(vec_i.y) * PROD_W'(GAIN_Q30);
  end

  always_comb begin
    cos_d = scale_out(cos_prod_q);
    sin_d = scale_out(sin_prod_q);
  end

  // Register the results
  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= vld_i;
      done_q     <= prod_vld_q;
    end
  end

  assign done_o   = done_q;
  assign cosine_o = cos_q;
  assign sine_o   = sin_q;

endmodule

/* src/cordic_sine_cosine.sv */
// Top level of the pipelined CORDIC sine/cosine unit.
// Takes one angle (signed Q2.16 radians, meant for plus or minus pi/2) at every
// clock edge with start high; busy stays low, so a new angle may follow in each
// cycle. Each angle runs through a chain of STEPS rotation cells, then a gain
// multiply stage and a rounding stage. That makes STEPS + 2 register stages, and
// the first of them loads at the transfer edge. The cosine and sine appear with
// done_o after the last of these stages, in input order. The result stands for one
// cycle only and cannot be held off, so capture it on done_o. Angles beyond
// plus or minus pi/2 are not reduced; outputs are clamped to plus or minus 1.0
// in signed Q1.16.
module cordic_sine_cosine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic signed [csc_pkg::ANGLE_W-1:0] angle_i,
  output logic                               busy,
  output logic                               done_o,
  output logic signed [csc_pkg::OUT_W-1:0]   cosine_o,
  output logic signed [csc_pkg::OUT_W-1:0]   sine_o
);
  import csc_pkg::*;

  logic     vld  [STEPS+1];
  csc_vec_t vec  [STEPS+1];

  // Pipeline never stalls
  assign busy = 1'b0;

  // Build the start vector from the angle
  always_comb begin
    vld[0]        = start;
    vec[0].x      = X_START;
    vec[0].y      = '0;
    vec[0].theta  = '0;
    vec[0].target = THETA_W'(angle_i) <<< TGT_SHIFT;
  end

  // Chain of rotation cells
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    csc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (STEP_W'(k)),
      .vld_i  (vld[k]),
      .vec_i  (vec[k]),
      .vld_o  (vld[k+1]),
      .vec_o  (vec[k+1])
    );
  end

  csc_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld[STEPS]),
    .vec_i    (vec[STEPS]),
    .done_o   (done_o),
    .cosine_o (cosine_o),
    .sine_o   (sine_o)
  );

endmodule

/* sim/cordic_sine_cosine_tb.sv */
// Self-checking testbench for the pipelined CORDIC sine/cosine unit.
`timescale 1ns / 1ps

module cordic_sine_cosine_tb;

  import csc_pkg::*;

  localparam int unsigned RANDOM_ANGLES = 1630;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = ITERATIONS + 6;
  localparam int unsigned REPORT_MAX    = 10;

  // Angle limits in signed Q2.16 radians and output limit in signed Q1.16.
  localparam int HALF_PI   = 102944;
  localparam int ANGLE_MAX = 131071;
  localparam int ANGLE_MIN = -131072;
  localparam longint UNIT_Q16 = 65536;

  // Own copy of round(atan(2^-i) * 2^30) and the gain in Q0.30.
  localparam longint ARCTAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687,  33543516,  16775851,  8388437,
    4194283,   2097149,   1048576,   524288,
    262144,    131072,    65536,     32768,
    16384,     8192,      4096,      2048,
    1024,      512,       256,       128,
    64,        32,        16,        8,
    4,         2,         1,         0
  };
  localparam longint SCALE_Q30 = 652039386;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [OUT_W-1:0]   cosine;
    logic signed [OUT_W-1:0]   sine;
  } trig_pair_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic signed [ANGLE_W-1:0] angle_i;
  logic                      busy;
  logic                      done_o;
  logic signed [OUT_W-1:0]   cosine_o;
  logic signed [OUT_W-1:0]   sine_o;

  logic signed [ANGLE_W-1:0] angle_q [$];
  trig_pair_t                trig_q [$];

  logic        took;
  int unsigned n_sent;
  int unsigned n_taken;
  int unsigned n_results;
  int unsigned n_clamped;
  int unsigned n_wide;
  int unsigned n_mismatch;
  int unsigned n_spurious;
  int unsigned stall_cnt;

  cordic_sine_cosine uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .angle_i  (angle_i),
    .busy     (busy),
    .done_o   (done_o),
    .cosine_o (cosine_o),
    .sine_o   (sine_o)
  );

  // Scale a Q.30 component by the gain, round half up to Q.16 and clamp to +-1.0.
  function automatic logic signed [OUT_W-1:0] scale_to_q16(input longint v);
    longint r;
    r = (v * SCALE_Q30 + (longint'(1) <<< 43)) >>> 44;
    if (r > UNIT_Q16) r = UNIT_Q16;
    if (r < -UNIT_Q16) r = -UNIT_Q16;
    return OUT_W'(r);
  endfunction

  // Rotate the unit vector toward the target angle and form cosine and sine.
  function automatic trig_pair_t rotate_to_angle(input logic signed [ANGLE_W-1:0] ang);
    trig_pair_t res;
    longint     goal;
    longint     acc;
    longint     vx;
    longint     vy;
    longint     sx;
    longint     sy;
    goal = longint'(ang) * 16384;
    acc  = 0;
    vx   = longint'(1) <<< 30;
    vy   = 0;
    for (int unsigned i = 0; i < ITERATIONS && i < 32; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (acc < goal) begin
        acc = acc + ARCTAN_Q30[i];
        vx  = vx - sx;
        vy  = vy + sy;
      end else begin
        acc = acc - ARCTAN_Q30[i];
        vx  = vx + sx;
        vy  = vy - sy;
      end
    end
    res.angle  = ang;
    res.cosine = scale_to_q16(vx);
    res.sine   = scale_to_q16(vy);
    return res;
  endfunction

  // Pick a sender idle rate from the phase of the run; stretches with no gaps too.
  function automatic int unsigned sender_idle_pct(input int unsigned sent);
    case ((sent / 150) % 4)
      0: begin
        return 0;
      end
      1: begin
        return 85;
      end
      2: begin
        return 0;
      end
      default: begin
        return 34;
      end
    endcase
  endfunction

  // Draw a random angle: mostly within +-pi/2, some near zero, at the limits
  // and over the whole 18-bit range.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return ANGLE_W'(int'($urandom_range(0, 2 * HALF_PI)) - HALF_PI);
    if (pick < 77) return ANGLE_W'(int'($urandom_range(0, 256)) - 128);
    if (pick < 87) begin
      if ($urandom_range(0, 1)) return ANGLE_W'(HALF_PI - int'($urandom_range(0, 64)));
      return ANGLE_W'(int'($urandom_range(0, 64)) - HALF_PI);
    end
    return ANGLE_W'($urandom);
  endfunction

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Drive the next angle at the falling edge once the previous one has transferred.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      angle_i <= '0;
    end else if (!start || took) begin
      if (angle_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct(n_sent)) begin
        start   <= 1'b1;
        angle_i <= angle_q.pop_front();
        n_sent  <= n_sent + 1;
      end else begin
        start   <= 1'b0;
        angle_i <= ANGLE_W'($urandom);
      end
    end
  end

  // Record transfers, check results against the oldest prediction, watch for stalls.
  always @(posedge clk_i) begin
    trig_pair_t exp_pair;
    took <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (start && !busy) begin
        exp_pair = rotate_to_angle(angle_i);
        trig_q.push_back(exp_pair);
        n_taken = n_taken + 1;
        if (angle_i > HALF_PI || angle_i < -HALF_PI) n_wide = n_wide + 1;
        if (exp_pair.cosine == UNIT_Q16 || exp_pair.sine == UNIT_Q16 ||
            exp_pair.sine == -UNIT_Q16) n_clamped = n_clamped + 1;
      end
      if (done_o) begin
        n_results = n_results + 1;
        if (trig_q.size() == 0) begin
          n_spurious = n_spurious + 1;
          if (n_mismatch + n_spurious <= REPORT_MAX)
            $display("ERROR: result with nothing pending: cosine %0d sine %0d",
                     cosine_o, sine_o);
        end else begin
          exp_pair = trig_q.pop_front();
          if (cosine_o !== exp_pair.cosine || sine_o !== exp_pair.sine) begin
            n_mismatch = n_mismatch + 1;
            if (n_mismatch + n_spurious <= REPORT_MAX) begin
              if (cosine_o !== exp_pair.cosine)
                $display("ERROR: angle %0d cosine expected %0d got %0d",
                         exp_pair.angle, exp_pair.cosine, cosine_o);
              if (sine_o !== exp_pair.sine)
                $display("ERROR: angle %0d sine expected %0d got %0d",
                         exp_pair.angle, exp_pair.sine, sine_o);
            end
          end
        end
      end
      if ((start && !busy) || done_o) begin
        stall_cnt = 0;
      end else begin
        stall_cnt = stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Fill the angle queue, release reset, then drain and report.
  initial begin
    int unsigned n_fail;
    took       = 1'b0;
    start      = 1'b0;
    angle_i    = '0;
    n_sent     = 0;
    n_taken    = 0;
    n_results  = 0;
    n_clamped  = 0;
    n_wide     = 0;
    n_mismatch = 0;
    n_spurious = 0;
    stall_cnt  = 0;
    rst_ni     = 1'b0;

    // Directed: zero, smallest steps, +-pi/2, +-pi/4, pi/6, pi/3,
    // out-of-range angles and the 18-bit extremes.
    angle_q = '{18'sd0, 18'sd1, -18'sd1, 18'sd2, 18'sd32, -18'sd32,
                18'sd102944, -18'sd102944, 18'sd102945, -18'sd102945,
                18'sd51472, -18'sd51472, 18'sd34315, 18'sd68629, -18'sd68629,
                18'sd65536, -18'sd65536, 18'sd100000, 18'sd131071, -18'sd131072,
                18'sd87381, -18'sd43690};
    for (int unsigned n = 0; n < RANDOM_ANGLES; n++) angle_q.push_back(random_angle());

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Hold until every angle has transferred and every result has come back.
    while (angle_q.size() != 0 || start || trig_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    n_fail = n_mismatch + n_spurious + trig_q.size();
    $display("Run covered %0d angles (%0d beyond +-pi/2) and %0d results, %0d at +-1.0.",
             n_taken, n_wide, n_results, n_clamped);
    $display("Mismatched results: %0d, results with nothing pending: %0d, left over: %0d.",
             n_mismatch, n_spurious, trig_q.size());
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/csc_pkg.sv
src/csc_cell.sv
src/csc_gain.sv
src/cordic_sine_cosine.sv
sim/cordic_sine_cosine_tb.sv
